// ===== hdl/rrle_pkg.sv =====
package rrle_pkg;

  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned PEND_W     = 6;
  localparam int unsigned CMDQ_DEPTH = 4;

  localparam logic [BYTE_W-1:0] NEWLINE_CODE = 8'h0A;

  // decoded kind of one queued command
  typedef enum logic {
    CMD_RECV = 1'b0,
    CMD_LINE = 1'b1
  } cmd_kind_e;

  // one classified item as it travels from the front to the engine
  typedef struct packed {
    cmd_kind_e         kind;
    logic [BYTE_W-1:0] rx_byte;
    logic [BYTE_W-1:0] cap;      // copy limit, max_len minus one, floored at zero
  } cmd_t;

endpackage

// ===== hdl/rrle_if.sv =====
interface rrle_item_if;
  import rrle_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [BYTE_W-1:0] rx_byte;
  logic [BYTE_W-1:0] max_len;

  modport source (output valid, action, rx_byte, max_len, input ready);
  modport sink   (input valid, action, rx_byte, max_len, output ready);
endinterface

interface rrle_result_if;
  import rrle_pkg::*;

  logic              valid;
  logic              ready;
  logic              line_found;
  logic              byte_valid;
  logic [BYTE_W-1:0] line_byte;
  logic              last;
  logic [PEND_W-1:0] pending;

  modport source (output valid, line_found, byte_valid, line_byte, last, pending, input ready);
  modport sink   (input valid, line_found, byte_valid, line_byte, last, pending, output ready);
endinterface

// ===== hdl/rrle_cmd_fifo.sv =====
module rrle_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_valid_i,
  output logic          push_ready_o,
  input  rrle_pkg::cmd_t push_cmd_i,
  output logic          pop_valid_o,
  input  logic          pop_ready_i,
  output rrle_pkg::cmd_t pop_cmd_o
);
  import rrle_pkg::*;

  localparam int unsigned PW = $clog2(CMDQ_DEPTH);

  cmd_t          slot_q [CMDQ_DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [PW:0]   count_q;
  logic          push, pop;

  assign push_ready_o = (count_q != (PW+1)'(CMDQ_DEPTH));
  assign pop_valid_o  = (count_q != '0);
  assign pop_cmd_o    = slot_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) wr_ptr_q <= wr_ptr_q + PW'(1);
      if (pop)  rd_ptr_q <= rd_ptr_q + PW'(1);
      if (push && !pop)      count_q <= count_q + (PW+1)'(1);
      else if (pop && !push) count_q <= count_q - (PW+1)'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) slot_q[wr_ptr_q] <= push_cmd_i;
  end

endmodule

// ===== hdl/rrle_engine.sv =====
module rrle_engine #(
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cmd_valid_i,
  output logic           cmd_ready_o,
  input  rrle_pkg::cmd_t cmd_i,
  rrle_result_if.source  res
);
  import rrle_pkg::*;

  localparam int unsigned AW = $clog2(RX_DEPTH);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_EMIT,
    ST_ONE
  } state_e;

  function automatic logic [AW-1:0] ptr_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(b);
    if (s >= (AW+1)'(RX_DEPTH)) s = s - (AW+1)'(RX_DEPTH);
    return s[AW-1:0];
  endfunction

  function automatic logic [AW-1:0] ptr_sub(input logic [AW-1:0] a, input logic [AW-1:0] b);
    logic [AW:0] s;
    s = (AW+1)'(a) + (AW+1)'(RX_DEPTH) - (AW+1)'(b);
    if (s >= (AW+1)'(RX_DEPTH)) s = s - (AW+1)'(RX_DEPTH);
    return s[AW-1:0];
  endfunction

  logic [BYTE_W-1:0] mem_q [RX_DEPTH];
  logic [BYTE_W-1:0] rdata_q;

  state_e            state_q, state_d;
  logic [AW-1:0]     wp_q, wp_d, rp_q, rp_d;
  logic [AW-1:0]     pend_q, pend_d;
  logic [AW-1:0]     iss_q, iss_d, chk_q, chk_d;
  logic [AW-1:0]     len_q, len_d, copy_q, copy_d;
  logic [BYTE_W-1:0] cap_q, cap_d;
  logic              found_q, found_d;
  logic              rdv_q, rdv_d;

  logic              out_vld_q, out_vld_d;
  logic              out_found_q, out_found_d;
  logic              out_bvld_q, out_bvld_d;
  logic [BYTE_W-1:0] out_byte_q, out_byte_d;
  logic              out_last_q, out_last_d;
  logic [AW-1:0]     out_pend_q, out_pend_d;

  logic              mem_we, rd_en;
  logic [AW-1:0]     raddr;
  logic [AW-1:0]     chk_inc;
  logic              out_free, stop, take, fin;

  assign chk_inc  = chk_q + AW'(1);
  assign out_free = !out_vld_q || res.ready;

  always_comb begin
    state_d     = state_q;
    wp_d        = wp_q;
    rp_d        = rp_q;
    pend_d      = pend_q;
    iss_d       = iss_q;
    chk_d       = chk_q;
    len_d       = len_q;
    copy_d      = copy_q;
    cap_d       = cap_q;
    found_d     = found_q;
    rdv_d       = rdv_q;
    out_vld_d   = out_vld_q && !res.ready;
    out_found_d = out_found_q;
    out_bvld_d  = out_bvld_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_pend_d  = out_pend_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    raddr       = '0;
    cmd_ready_o = 1'b0;
    stop        = 1'b0;
    take        = 1'b0;
    fin         = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_ready_o = 1'b1;
          if (cmd_i.kind == CMD_RECV) begin
            mem_we = 1'b1;
            wp_d   = ptr_add(wp_q, AW'(1));
          end else begin
            pend_d  = ptr_sub(wp_q, rp_q);
            cap_d   = cmd_i.cap;
            iss_d   = '0;
            chk_d   = '0;
            rdv_d   = 1'b0;
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        // reads are pipelined: one issued and one checked per cycle
        if (rdv_q) begin
          if (rdata_q == NEWLINE_CODE) begin
            stop    = 1'b1;
            found_d = 1'b1;
            len_d   = chk_inc;
            copy_d  = (BYTE_W'(chk_inc) < cap_q) ? chk_inc : cap_q[AW-1:0];
            iss_d   = '0;
            chk_d   = '0;
            rdv_d   = 1'b0;
            state_d = (copy_d == '0) ? ST_ONE : ST_EMIT;
          end else if (chk_inc == pend_q) begin
            stop    = 1'b1;
            found_d = 1'b0;
            rdv_d   = 1'b0;
            state_d = ST_ONE;
          end else begin
            chk_d = chk_inc;
          end
        end else if (pend_q == '0) begin
          stop    = 1'b1;
          found_d = 1'b0;
          state_d = ST_ONE;
        end
        if (!stop) begin
          if (iss_q < pend_q) begin
            rd_en = 1'b1;
            raddr = ptr_add(rp_q, iss_q);
            iss_d = iss_q + AW'(1);
            rdv_d = 1'b1;
          end else begin
            rdv_d = 1'b0;
          end
        end
      end

      ST_EMIT: begin
        take = rdv_q && out_free;
        if (take) begin
          out_vld_d   = 1'b1;
          out_found_d = 1'b1;
          out_bvld_d  = 1'b1;
          out_byte_d  = rdata_q;
          out_last_d  = (chk_inc == copy_q);
          out_pend_d  = pend_q;
          chk_d       = chk_inc;
          if (chk_inc == copy_q) begin
            fin     = 1'b1;
            rp_d    = ptr_add(rp_q, len_q);
            rdv_d   = 1'b0;
            state_d = ST_IDLE;
          end
        end
        if (!fin && (!rdv_q || take)) begin
          if (iss_q < copy_q) begin
            rd_en = 1'b1;
            raddr = ptr_add(rp_q, iss_q);
            iss_d = iss_q + AW'(1);
            rdv_d = 1'b1;
          end else begin
            rdv_d = 1'b0;
          end
        end
      end

      ST_ONE: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_found_d = found_q;
          out_bvld_d  = 1'b0;
          out_byte_d  = '0;
          out_last_d  = 1'b1;
          out_pend_d  = pend_q;
          if (found_q) rp_d = ptr_add(rp_q, len_q);
          state_d = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      wp_q      <= '0;
      rp_q      <= '0;
      rdv_q     <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      wp_q      <= wp_d;
      rp_q      <= rp_d;
      rdv_q     <= rdv_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q      <= pend_d;
    iss_q       <= iss_d;
    chk_q       <= chk_d;
    len_q       <= len_d;
    copy_q      <= copy_d;
    cap_q       <= cap_d;
    found_q     <= found_d;
    out_found_q <= out_found_d;
    out_bvld_q  <= out_bvld_d;
    out_byte_q  <= out_byte_d;
    out_last_q  <= out_last_d;
    out_pend_q  <= out_pend_d;
  end

  // byte store: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[wp_q] <= cmd_i.rx_byte;
    if (rd_en)  rdata_q <= mem_q[raddr];
  end

  assign res.valid      = out_vld_q;
  assign res.line_found = out_found_q;
  assign res.byte_valid = out_bvld_q;
  assign res.line_byte  = out_byte_q;
  assign res.last       = out_last_q;
  assign res.pending    = PEND_W'(out_pend_q);

endmodule

// ===== hdl/rx_ring_line_extractor.sv =====
// rx_ring_line_extractor: receive ring buffer that hands out complete lines
//
// item channel (sink): action 0 stores rx_byte in the ring, action 1 asks for
// one newline-terminated line, copied to at most max_len minus one bytes.
// result channel (source): one beat per copied line byte, last set on the
// final one; a request with no complete line, or an empty copy, answers with
// a single beat that has byte_valid low. pending is the fill before the
// request and repeats on every beat of it.
// a four-entry command queue decouples the front from the engine. a stored
// byte passes through the queue before the engine writes it to the ring. a
// line request first scans the stored bytes (one registered ring read per
// cycle), then sends one result beat per cycle while the receiver keeps up.
// there is no full check: writing past the depth wraps and overwrites.
// reset clears both ring positions and the queue; the ring contents are not
// cleared and need no clearing pass.
// when the receiver stalls the result register holds its beat, the engine
// pauses, and once the queue fills the item channel drops ready.
module rx_ring_line_extractor #(
  parameter int unsigned RX_DEPTH = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  rrle_item_if.sink   item,
  rrle_result_if.source result
);
  import rrle_pkg::*;

  cmd_t front_cmd;
  cmd_t queued_cmd;
  logic q_valid;
  logic q_ready;
  logic push_ready;

  // front: classify the beat and turn max_len into the copy limit
  always_comb begin
    front_cmd.kind    = item.action ? CMD_LINE : CMD_RECV;
    front_cmd.rx_byte = item.rx_byte;
    front_cmd.cap     = (item.max_len == '0) ? '0 : item.max_len - BYTE_W'(1);
  end

  assign item.ready = push_ready;

  rrle_cmd_fifo u_cmd_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (item.valid),
    .push_ready_o (push_ready),
    .push_cmd_i   (front_cmd),
    .pop_valid_o  (q_valid),
    .pop_ready_i  (q_ready),
    .pop_cmd_o    (queued_cmd)
  );

  // back: ring store, line scan and copy out
  rrle_engine #(
    .RX_DEPTH (RX_DEPTH)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (q_valid),
    .cmd_ready_o (q_ready),
    .cmd_i       (queued_cmd),
    .res         (result)
  );

  // a not-found answer is always a single closing beat without data
  a_notfound_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result.valid && !result.line_found) |-> (result.last && !result.byte_valid))
    else $error("not-found result is not a single empty beat");

  // data beats only come from a found line
  a_byte_needs_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result.valid && result.byte_valid) |-> result.line_found)
    else $error("line byte without a found line");

  // beats without data carry a zero byte
  a_empty_byte_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result.valid && !result.byte_valid) |-> (result.line_byte == '0))
    else $error("empty beat carries a nonzero byte");

  // the engine only takes a command that the queue offers
  a_pop_with_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_ready |-> q_valid)
    else $error("command taken from an empty queue");

endmodule
